// ----- rtl/core/lr_pkg.sv -----
// line rasterizer package: widths, codes, and the structs passed between modules
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

  localparam int MAX_RES   = 2048;
  localparam int COORD_W   = 11;
  localparam int RES_W     = 12;
  localparam int ADDR_W    = 22;
  localparam int COLOR_W   = 8;
  localparam int SPAN_W    = 12;
  localparam int ERR_W     = 12;   // error term stays in 0..2D-1, at most 4093
  localparam int CFG_IDX_W = 1;

  localparam logic [RES_W-1:0] H_RES_RESET = RES_W'(1024);
  localparam logic [RES_W-1:0] V_RES_RESET = RES_W'(768);
  localparam logic [RES_W-1:0] MAX_RES_V   = RES_W'(MAX_RES);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_H_RES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_V_RES = 1'b1;

  // request codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    KIND_IDLE   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_PIXEL  = 2'd3
  } kind_t;

  // decoded start request
  typedef struct packed {
    logic                      ok;
    logic                      x_is_major;
    logic [COORD_W-1:0]        major_pos;
    logic [COORD_W-1:0]        minor_pos;
    logic [SPAN_W-1:0]         major_span;
    logic signed [SPAN_W-1:0]  minor_span;
  } line_setup_t;

  // one result transaction
  typedef struct packed {
    kind_t               kind;
    logic [ADDR_W-1:0]   pixel_address;
    logic [COLOR_W-1:0]  pixel_color;
    logic                last;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/lr_req_if.sv -----
// request channel of the line rasterizer: valid/ready plus start and pixel fields
// depends on lr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface lr_req_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [lr_pkg::COORD_W-1:0]    x_start;
  logic [lr_pkg::COORD_W-1:0]    y_start;
  logic [lr_pkg::COORD_W-1:0]    x_end;
  logic [lr_pkg::COORD_W-1:0]    y_end;
  logic [lr_pkg::COLOR_W-1:0]    paint;

  modport source (output valid, func, x_start, y_start, x_end, y_end, paint, input ready);
  modport sink   (input valid, func, x_start, y_start, x_end, y_end, paint, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lr_rsp_if.sv -----
// result channel of the line rasterizer: valid/ready plus pixel fields
// depends on lr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface lr_rsp_if;
  logic                         valid;
  logic                         ready;
  lr_pkg::kind_t                kind;
  logic [lr_pkg::ADDR_W-1:0]    pixel_address;
  logic [lr_pkg::COLOR_W-1:0]   pixel_color;
  logic                         last;

  modport source (output valid, kind, pixel_address, pixel_color, last, input ready);
  modport sink   (input valid, kind, pixel_address, pixel_color, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lr_setup.sv -----
// start decode: screen check, major axis choice, endpoint order and spans
// depends on lr_pkg
`timescale 1ns / 1ps
`default_nettype none

module lr_setup (
  input  wire logic [lr_pkg::COORD_W-1:0] x_start,
  input  wire logic [lr_pkg::COORD_W-1:0] y_start,
  input  wire logic [lr_pkg::COORD_W-1:0] x_end,
  input  wire logic [lr_pkg::COORD_W-1:0] y_end,
  input  wire logic [lr_pkg::RES_W-1:0]   h_res,
  input  wire logic [lr_pkg::RES_W-1:0]   v_res,
  output lr_pkg::line_setup_t             setup
);

  logic                               start_on, end_on;
  logic signed [lr_pkg::COORD_W:0]    dx, dy;
  logic [lr_pkg::COORD_W-1:0]         adx, ady;
  logic                               x_major;
  logic [lr_pkg::COORD_W-1:0]         ma_lo, ma_hi, mi_lo, mi_hi;

  // both endpoints must be inside the screen
  assign start_on = ({1'b0, x_start} < h_res) && ({1'b0, y_start} < v_res) &&
                    ({1'b0, x_start} < lr_pkg::MAX_RES_V) &&
                    ({1'b0, y_start} < lr_pkg::MAX_RES_V);
  assign end_on   = ({1'b0, x_end} < h_res) && ({1'b0, y_end} < v_res) &&
                    ({1'b0, x_end} < lr_pkg::MAX_RES_V) &&
                    ({1'b0, y_end} < lr_pkg::MAX_RES_V);

  // absolute spans and axis choice, a tie goes to y
  assign dx  = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
  assign dy  = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
  assign adx = dx[lr_pkg::COORD_W] ? lr_pkg::COORD_W'(-dx) : dx[lr_pkg::COORD_W-1:0];
  assign ady = dy[lr_pkg::COORD_W] ? lr_pkg::COORD_W'(-dy) : dy[lr_pkg::COORD_W-1:0];
  assign x_major = adx > ady;

  // order endpoints by major coordinate
  always_comb begin
    if (x_major) begin
      if (x_start <= x_end) begin
        ma_lo = x_start; ma_hi = x_end; mi_lo = y_start; mi_hi = y_end;
      end else begin
        ma_lo = x_end; ma_hi = x_start; mi_lo = y_end; mi_hi = y_start;
      end
    end else begin
      if (y_start <= y_end) begin
        ma_lo = y_start; ma_hi = y_end; mi_lo = x_start; mi_hi = x_end;
      end else begin
        ma_lo = y_end; ma_hi = y_start; mi_lo = x_end; mi_hi = x_start;
      end
    end
  end

  assign setup.ok         = start_on && end_on;
  assign setup.x_is_major = x_major;
  assign setup.major_pos  = ma_hi;
  assign setup.minor_pos  = mi_hi;
  assign setup.major_span = {1'b0, ma_hi - ma_lo};
  assign setup.minor_span = $signed({1'b0, mi_hi}) - $signed({1'b0, mi_lo});

endmodule

`default_nettype wire

// ----- rtl/core/lr_walker.sv -----
// line state and one-step walker: holds the current line, builds each result
// and advances the error term per accepted non-final pixel; depends on lr_pkg
`timescale 1ns / 1ps
`default_nettype none

module lr_walker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        take,
  input  wire logic                        func,
  input  wire lr_pkg::line_setup_t         setup,
  input  wire logic [lr_pkg::COLOR_W-1:0]  paint,
  input  wire logic [lr_pkg::RES_W-1:0]    h_res,
  output lr_pkg::result_t                  res,
  output logic                             busy
);

  logic                              x_is_major;
  logic [lr_pkg::COORD_W-1:0]        major_pos, minor_pos;
  logic [lr_pkg::SPAN_W-1:0]         steps_left, major_span;
  logic signed [lr_pkg::SPAN_W-1:0]  minor_span;
  logic [lr_pkg::ERR_W-1:0]          error_term;
  logic [lr_pkg::COLOR_W-1:0]        line_color;

  logic [lr_pkg::COORD_W-1:0]        px, py;
  logic [lr_pkg::ADDR_W:0]           row_base;
  logic [lr_pkg::ADDR_W-1:0]         address;
  logic                              final_px;
  logic [lr_pkg::ERR_W-1:0]          two_d;
  logic signed [lr_pkg::ERR_W+1:0]   err_sub;
  logic [lr_pkg::ERR_W-1:0]          error_next;
  logic [lr_pkg::COORD_W-1:0]        minor_next;

  // pixel coordinates and frame buffer offset
  assign px       = x_is_major ? major_pos : minor_pos;
  assign py       = x_is_major ? minor_pos : major_pos;
  assign row_base = {1'b0, py} * h_res;
  assign address  = row_base[lr_pkg::ADDR_W-1:0] + {{(lr_pkg::ADDR_W-lr_pkg::COORD_W){1'b0}}, px};
  assign final_px = steps_left == lr_pkg::SPAN_W'(1);

  // error term update, one correction brings it back into 0..2D-1
  assign two_d   = {major_span[lr_pkg::SPAN_W-2:0], 1'b0};
  assign err_sub = $signed({2'b00, error_term}) -
                   $signed({minor_span[lr_pkg::SPAN_W-1], minor_span, 1'b0});
  always_comb begin
    if (err_sub < 0) begin
      error_next = lr_pkg::ERR_W'(err_sub + $signed({2'b00, two_d}));
      minor_next = minor_pos - lr_pkg::COORD_W'(1);
    end else if (err_sub >= $signed({2'b00, two_d})) begin
      error_next = lr_pkg::ERR_W'(err_sub - $signed({2'b00, two_d}));
      minor_next = minor_pos + lr_pkg::COORD_W'(1);
    end else begin
      error_next = err_sub[lr_pkg::ERR_W-1:0];
      minor_next = minor_pos;
    end
  end

  // result of the transaction at the input
  always_comb begin
    res = '0;
    if (func == lr_pkg::FUNC_START) begin
      res.kind = setup.ok ? lr_pkg::KIND_ACCEPT : lr_pkg::KIND_REJECT;
    end else if (busy) begin
      res.kind          = lr_pkg::KIND_PIXEL;
      res.pixel_address = address;
      res.pixel_color   = line_color;
      res.last          = final_px;
    end else begin
      res.kind = lr_pkg::KIND_IDLE;
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (take) begin
      if (func == lr_pkg::FUNC_START) begin
        busy <= setup.ok;
      end else if (busy && final_px) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (func == lr_pkg::FUNC_START) begin
        x_is_major <= setup.x_is_major;
        major_pos  <= setup.major_pos;
        minor_pos  <= setup.minor_pos;
        major_span <= setup.major_span;
        minor_span <= setup.minor_span;
        error_term <= setup.major_span[lr_pkg::ERR_W-1:0];
        steps_left <= setup.major_span + lr_pkg::SPAN_W'(1);
        line_color <= paint;
      end else if (busy) begin
        steps_left <= steps_left - lr_pkg::SPAN_W'(1);
        if (!final_px) begin
          major_pos  <= major_pos - lr_pkg::COORD_W'(1);
          minor_pos  <= minor_next;
          error_term <= error_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/line_rasterizer.sv -----
// line rasterizer top level: configuration registers, output register, checks
// depends on lr_pkg, lr_req_if, lr_rsp_if, lr_setup, lr_walker
`timescale 1ns / 1ps
`default_nettype none

// Every request transaction gives exactly one result transaction: a start
// (func 0) answers accepted or rejected, each pixel request (func 1) answers
// one pixel from the far endpoint toward the near one, with last set on the
// final pixel, or idle when no line is in progress. The block takes one
// request per clock cycle unless rsp stalls; each result appears in the cycle
// after its request is accepted, from a single output register, and a new
// request is taken whenever that register is empty or is being emptied in the
// same cycle. The per-cycle path is the 11x12 row-offset multiply and add of
// the walker. The user writes h_res and v_res via cfg_we/cfg_index/cfg_data
// only while idle, unenforced by the block; reset sets them to 1024 and 768.
module line_rasterizer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  lr_req_if.sink                             req,
  lr_rsp_if.source                           rsp,
  input  wire logic                          cfg_we,
  input  wire logic [lr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lr_pkg::RES_W-1:0]      cfg_data
);

  logic [lr_pkg::RES_W-1:0] h_res, v_res;
  logic                     accept;
  logic                     line_busy;
  lr_pkg::line_setup_t      setup;
  lr_pkg::result_t          res;
  lr_pkg::result_t          out_data;
  logic                     out_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      h_res <= lr_pkg::H_RES_RESET;
      v_res <= lr_pkg::V_RES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lr_pkg::REG_H_RES: h_res <= cfg_data;
        lr_pkg::REG_V_RES: v_res <= cfg_data;
        default: ;
      endcase
    end
  end

  // request transaction handshake
  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  lr_setup u_setup (
    .x_start (req.x_start),
    .y_start (req.y_start),
    .x_end   (req.x_end),
    .y_end   (req.y_end),
    .h_res   (h_res),
    .v_res   (v_res),
    .setup   (setup)
  );

  lr_walker u_walker (
    .clk   (clk),
    .rst   (rst),
    .take  (accept),
    .func  (req.func),
    .setup (setup),
    .paint (req.paint),
    .h_res (h_res),
    .res   (res),
    .busy  (line_busy)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.kind          = out_data.kind;
  assign rsp.pixel_address = out_data.pixel_address;
  assign rsp.pixel_color   = out_data.pixel_color;
  assign rsp.last          = out_data.last;

  // a rejected start leaves no line in progress
  a_reject_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && res.kind == lr_pkg::KIND_REJECT) |=> !line_busy)
    else $error("line still in progress after rejected start");

  // the last pixel ends the line
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (accept && res.kind == lr_pkg::KIND_PIXEL && res.last) |=> !line_busy)
    else $error("line still in progress after last pixel");

  // every accepted request shows up as a result the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> (rsp.valid && rsp.kind == $past(res.kind)))
    else $error("result missing after accepted request");

  // only pixel results carry a payload
  a_quiet_payload: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.kind != lr_pkg::KIND_PIXEL) |->
      (rsp.pixel_address == '0 && rsp.pixel_color == '0 && !rsp.last))
    else $error("non-pixel result carries payload");

endmodule

`default_nettype wire
